/* rtl/sobel_edge_magnitude_core_macros.svh */
// ----------------------------------------------------------------------------
// sobel edge magnitude core - assertion macros
// clocked assertion shorthands used by the checker file sem_checker
// ----------------------------------------------------------------------------
`ifndef SOBEL_EDGE_MAGNITUDE_CORE_MACROS_SVH
`define SOBEL_EDGE_MAGNITUDE_CORE_MACROS_SVH

// property checked on every rising edge outside reset
`define SEM_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// property that must also hold across reset
`define SEM_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

/* rtl/sem_pkg.sv */
// ----------------------------------------------------------------------------
// sem_pkg
// shared widths, reset values, register map, state codes and the
// square-root step of the sobel edge magnitude core
// ----------------------------------------------------------------------------
`default_nettype none

package sem_pkg;

    localparam int PIX_W  = 8;
    localparam int X_W    = 10;
    localparam int Y_W    = 9;
    localparam int MAG_W  = 8;
    localparam int CFG_DW = 32;
    localparam int CFG_AW = 3;

    localparam int MAX_WIDTH_DEF  = 640;
    localparam int MAX_HEIGHT_DEF = 480;

    localparam logic [X_W-1:0] WIDTH_RST  = 10'd320;
    localparam logic [Y_W-1:0] HEIGHT_RST = 9'd240;

    // register index, taken from paddr[2]
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // squared magnitude at or above this saturates the output
    localparam logic [20:0] SAT_LIMIT = 21'd65025;
    localparam logic [MAG_W-1:0] MAG_SAT = 8'd255;

    // highest trial bit of the 16-bit root
    localparam logic [15:0] ROOT_TOP = 16'h4000;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_CALC = 6'b000010,
        ST_SQR  = 6'b000100,
        ST_SUM  = 6'b001000,
        ST_ROOT = 6'b010000,
        ST_EMIT = 6'b100000
    } state_t;

    typedef struct packed {
        logic [15:0] rem;
        logic [15:0] res;
    } root_t;

    function automatic logic signed [11:0] to_s12(input logic [PIX_W-1:0] v);
        to_s12 = $signed({4'b0000, v});
    endfunction

    // one step of the bitwise integer square root
    function automatic root_t sqrt_step(input root_t cur, input logic [15:0] bit_w);
        root_t       nxt;
        logic [16:0] cmp;
        cmp = {1'b0, cur.res} + {1'b0, bit_w};
        if ({1'b0, cur.rem} >= cmp) begin
            nxt.rem = cur.rem - cmp[15:0];
            nxt.res = (cur.res >> 1) + bit_w;
        end else begin
            nxt.rem = cur.rem;
            nxt.res = cur.res >> 1;
        end
        sqrt_step = nxt;
    endfunction

endpackage

`default_nettype wire

/* rtl/sobel_edge_magnitude_core.sv */
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_core
// sequence: an accepted request goes to CALC; interior pixels then pass SQR,
//   SUM, the ROOT loop (skipped when the magnitude saturates) and EMIT, which
//   loads the output register once it is free and so raises m_valid;
//   border pixels finish in CALC; s_ready is high only in IDLE, so a new
//   request is taken only after the one before it has finished
// reset: synchronous active-low aresetn clears counters, window and control;
//   the line memory is not cleared, registers return to 320 x 240
// ----------------------------------------------------------------------------
`default_nettype none

module sobel_edge_magnitude_core #(
    parameter int MAX_WIDTH  = sem_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = sem_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    // pixel requests
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [sem_pkg::PIX_W-1:0]   s_pixel,
    input  wire logic                        s_start_of_frame,
    // magnitude results
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [sem_pkg::MAG_W-1:0]        m_edge_magnitude,
    output logic [sem_pkg::X_W-1:0]          m_center_x,
    output logic [sem_pkg::Y_W-1:0]          m_center_y,
    output logic                             m_last_of_frame,
    // configuration port
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [sem_pkg::CFG_AW-1:0]  paddr,
    input  wire logic [sem_pkg::CFG_DW-1:0]  pwdata,
    output logic [sem_pkg::CFG_DW-1:0]       prdata,
    output logic                             pready
);

    import sem_pkg::*;

    // line memory address, column and row counter widths
    localparam int AW  = $clog2(MAX_WIDTH);
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int HW  = $clog2(MAX_HEIGHT + 1);
    // widths for clamping the registers and for the centre coordinates
    localparam int WCW = (WW > X_W) ? WW : X_W;
    localparam int HCW = (HW > Y_W) ? HW : Y_W;

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    state_t              state_reg, state_next;
    logic [X_W-1:0]      img_w_reg, img_w_next;
    logic [Y_W-1:0]      img_h_reg, img_h_next;
    logic [WW-1:0]       col_reg, col_next;
    logic [HW-1:0]       row_reg, row_next;
    logic [PIX_W-1:0]    win_reg [6];
    logic [PIX_W-1:0]    win_next [6];

    // per-request payload, held while the request is worked on
    logic [PIX_W-1:0]    pix_reg, pix_next;
    logic [WW-1:0]       cur_col_reg, cur_col_next;
    logic [HW-1:0]       cur_row_reg, cur_row_next;
    logic                emit_reg, emit_next;
    logic                last_reg, last_next;
    logic signed [11:0]  gx_reg, gx_next;
    logic signed [11:0]  gy_reg, gy_next;
    logic [19:0]         sqx_reg, sqx_next;
    logic [19:0]         sqy_reg, sqy_next;
    root_t               root_reg, root_next;
    logic [1:0]          step_reg, step_next;
    logic [MAG_W-1:0]    mag_reg, mag_next;

    // output stage
    logic                m_valid_reg, m_valid_next;
    logic [MAG_W-1:0]    m_mag_reg, m_mag_next;
    logic [X_W-1:0]      m_cx_reg, m_cx_next;
    logic [Y_W-1:0]      m_cy_reg, m_cy_next;
    logic                m_last_reg, m_last_next;

    // line memory: upper byte is the line above the previous one, lower byte
    // the previous line, both at the same column
    logic [15:0]         line_mem [MAX_WIDTH];
    logic [15:0]         mem_rd_reg;

    // ------------------------------------------------------------------
    // effective frame size: registers clamped to [3, max]
    // ------------------------------------------------------------------
    logic [WCW-1:0]      iw_ext;
    logic [WCW-1:0]      eff_w_ext;
    logic [HCW-1:0]      ih_ext;
    logic [HCW-1:0]      eff_h_ext;
    logic [WW-1:0]       eff_w;
    logic [HW-1:0]       eff_h;

    assign iw_ext    = WCW'(img_w_reg);
    assign eff_w_ext = (iw_ext < WCW'(3)) ? WCW'(3) :
                       ((iw_ext > WCW'(MAX_WIDTH)) ? WCW'(MAX_WIDTH) : iw_ext);
    assign eff_w     = eff_w_ext[WW-1:0];

    assign ih_ext    = HCW'(img_h_reg);
    assign eff_h_ext = (ih_ext < HCW'(3)) ? HCW'(3) :
                       ((ih_ext > HCW'(MAX_HEIGHT)) ? HCW'(MAX_HEIGHT) : ih_ext);
    assign eff_h     = eff_h_ext[HW-1:0];

    // ------------------------------------------------------------------
    // position of the incoming pixel and of the one after it
    // ------------------------------------------------------------------
    logic [WW-1:0]       c_base, c_acc, c_inc;
    logic [HW-1:0]       r_base, r_acc, r_inc;
    logic [HW:0]         r_tmp;
    logic                wrap_in, wrap_out;
    logic [WW-1:0]       c_after;
    logic [HW-1:0]       r_after;

    always_comb begin
        // start of frame restarts at column 0, row 0
        c_base  = s_start_of_frame ? '0 : col_reg;
        r_base  = s_start_of_frame ? '0 : row_reg;
        // a width lowered mid-frame can leave the column past the line end
        wrap_in = (c_base >= eff_w);
        c_acc   = wrap_in ? '0 : c_base;
        r_tmp   = wrap_in ? ({1'b0, r_base} + (HW+1)'(1)) : {1'b0, r_base};
        r_acc   = (r_tmp >= {1'b0, eff_h}) ? '0 : r_tmp[HW-1:0];
        // advance past this pixel, wrapping at line and frame end
        c_inc    = c_acc + WW'(1);
        r_inc    = r_acc + HW'(1);
        wrap_out = (c_inc >= eff_w);
        c_after  = wrap_out ? '0 : c_inc;
        if (wrap_out) begin
            r_after = (r_inc >= eff_h) ? '0 : r_inc;
        end else begin
            r_after = r_acc;
        end
    end

    // ------------------------------------------------------------------
    // datapath pieces
    // ------------------------------------------------------------------
    logic [PIX_W-1:0]    top_pix, mid_pix;
    logic signed [11:0]  t_s, m_s, p_s, lt_s, lm_s, lb_s, ct_s, cb_s;
    logic signed [23:0]  sq_x, sq_y;
    logic [20:0]         sum_w;
    logic [15:0]         bit0, bit1;
    root_t               root_a, root_b;
    logic [WCW-1:0]      cx_ext;
    logic [HCW-1:0]      cy_ext;

    assign top_pix = mem_rd_reg[15:8];
    assign mid_pix = mem_rd_reg[7:0];

    assign t_s  = to_s12(top_pix);
    assign m_s  = to_s12(mid_pix);
    assign p_s  = to_s12(pix_reg);
    assign lt_s = to_s12(win_reg[0]);
    assign lm_s = to_s12(win_reg[1]);
    assign lb_s = to_s12(win_reg[2]);
    assign ct_s = to_s12(win_reg[3]);
    assign cb_s = to_s12(win_reg[5]);

    // squares stay below 2^20 since each gradient is within +-1020
    assign sq_x  = gx_reg * gx_reg;
    assign sq_y  = gy_reg * gy_reg;
    assign sum_w = {1'b0, sqx_reg} + {1'b0, sqy_reg};

    // two root steps per cycle, trial bit falls by four places each cycle
    assign bit0   = ROOT_TOP >> {step_reg, 2'b00};
    assign bit1   = bit0 >> 2;
    assign root_a = sqrt_step(root_reg, bit0);
    assign root_b = sqrt_step(root_a, bit1);

    // centre lies one column left and one row up of the newest pixel
    assign cx_ext = WCW'(cur_col_reg) - WCW'(1);
    assign cy_ext = HCW'(cur_row_reg) - HCW'(1);

    // ------------------------------------------------------------------
    // control and next-state logic
    // ------------------------------------------------------------------
    always_comb begin
        state_next   = state_reg;
        img_w_next   = img_w_reg;
        img_h_next   = img_h_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        win_next     = win_reg;
        pix_next     = pix_reg;
        cur_col_next = cur_col_reg;
        cur_row_next = cur_row_reg;
        emit_next    = emit_reg;
        last_next    = last_reg;
        gx_next      = gx_reg;
        gy_next      = gy_reg;
        sqx_next     = sqx_reg;
        sqy_next     = sqy_reg;
        root_next    = root_reg;
        step_next    = step_reg;
        mag_next     = mag_reg;
        m_mag_next   = m_mag_reg;
        m_cx_next    = m_cx_reg;
        m_cy_next    = m_cy_reg;
        m_last_next  = m_last_reg;

        // output register empties when the result is taken
        m_valid_next = m_valid_reg && !m_ready;

        // register writes land on the access phase
        if (psel && penable && pwrite) begin
            case (paddr[2])
                REG_WIDTH:  img_w_next = pwdata[X_W-1:0];
                REG_HEIGHT: img_h_next = pwdata[Y_W-1:0];
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                // take the request, issue the line memory read at its column
                if (s_valid) begin
                    col_next     = c_after;
                    row_next     = r_after;
                    pix_next     = s_pixel;
                    cur_col_next = c_acc;
                    cur_row_next = r_acc;
                    emit_next    = (c_acc >= WW'(2)) && (r_acc >= HW'(2));
                    last_next    = (c_acc == eff_w - WW'(1)) && (r_acc == eff_h - HW'(1));
                    state_next   = ST_CALC;
                end
            end
            ST_CALC: begin
                // line data is back: shift the window, form both gradients
                win_next[0] = win_reg[3];
                win_next[1] = win_reg[4];
                win_next[2] = win_reg[5];
                win_next[3] = top_pix;
                win_next[4] = mid_pix;
                win_next[5] = pix_reg;
                gx_next = (t_s - lt_s) + ((m_s - lm_s) <<< 1) + (p_s - lb_s);
                gy_next = (lb_s + (cb_s <<< 1) + p_s) - (lt_s + (ct_s <<< 1) + t_s);
                // border pixels finish here with no result
                state_next = emit_reg ? ST_SQR : ST_IDLE;
            end
            ST_SQR: begin
                sqx_next   = sq_x[19:0];
                sqy_next   = sq_y[19:0];
                state_next = ST_SUM;
            end
            ST_SUM: begin
                root_next.rem = sum_w[15:0];
                root_next.res = '0;
                step_next     = '0;
                if (sum_w >= SAT_LIMIT) begin
                    mag_next   = MAG_SAT;
                    state_next = ST_EMIT;
                end else begin
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT: begin
                root_next = root_b;
                step_next = step_reg + 2'd1;
                if (step_reg == 2'd3) begin
                    mag_next   = root_b.res[MAG_W-1:0];
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                // wait for the output register to free up
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_mag_next   = mag_reg;
                    m_cx_next    = cx_ext[X_W-1:0];
                    m_cy_next    = cy_ext[Y_W-1:0];
                    m_last_next  = last_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            img_w_reg   <= WIDTH_RST;
            img_h_reg   <= HEIGHT_RST;
            col_reg     <= '0;
            row_reg     <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < 6; i++) begin
                win_reg[i] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            img_w_reg   <= img_w_next;
            img_h_reg   <= img_h_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            m_valid_reg <= m_valid_next;
            win_reg     <= win_next;
        end
        pix_reg     <= pix_next;
        cur_col_reg <= cur_col_next;
        cur_row_reg <= cur_row_next;
        emit_reg    <= emit_next;
        last_reg    <= last_next;
        gx_reg      <= gx_next;
        gy_reg      <= gy_next;
        sqx_reg     <= sqx_next;
        sqy_reg     <= sqy_next;
        root_reg    <= root_next;
        step_reg    <= step_next;
        mag_reg     <= mag_next;
        m_mag_reg   <= m_mag_next;
        m_cx_reg    <= m_cx_next;
        m_cy_reg    <= m_cy_next;
        m_last_reg  <= m_last_next;
    end

    // ------------------------------------------------------------------
    // line memory: read on accept, written back in the CALC state that follows;
    // the next read of the same column comes only after that write
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_valid) begin
            mem_rd_reg <= line_mem[c_acc[AW-1:0]];
        end
        if (state_reg == ST_CALC) begin
            // previous line moves up, new pixel becomes the previous line
            line_mem[cur_col_reg[AW-1:0]] <= {mid_pix, pix_reg};
        end
    end

    // ------------------------------------------------------------------
    // ports
    // ------------------------------------------------------------------
    assign s_ready          = (state_reg == ST_IDLE);
    assign m_valid          = m_valid_reg;
    assign m_edge_magnitude = m_mag_reg;
    assign m_center_x       = m_cx_reg;
    assign m_center_y       = m_cy_reg;
    assign m_last_of_frame  = m_last_reg;
    assign pready           = 1'b1;

    always_comb begin
        case (paddr[2])
            REG_WIDTH:  prdata = CFG_DW'(img_w_reg);
            REG_HEIGHT: prdata = CFG_DW'(img_h_reg);
            default:    prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

/* rtl/sem_checker.sv */
// ----------------------------------------------------------------------------
// sem_checker
// port-level checks of the sobel edge magnitude core, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "sobel_edge_magnitude_core_macros.svh"

module sem_checker (
    input wire logic                        aclk,
    input wire logic                        aresetn,
    input wire logic                        s_valid,
    input wire logic                        s_ready,
    input wire logic                        m_valid,
    input wire logic                        m_ready,
    input wire logic [sem_pkg::MAG_W-1:0]   m_edge_magnitude,
    input wire logic [sem_pkg::X_W-1:0]     m_center_x,
    input wire logic [sem_pkg::Y_W-1:0]     m_center_y,
    input wire logic                        m_last_of_frame
);

    import sem_pkg::*;

    // a stalled result keeps its contents
    `SEM_ASSERT(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_edge_magnitude) && $stable(m_center_x) && $stable(m_center_y) && $stable(m_last_of_frame), "result changed while stalled")

    // one request at a time: busy right after an accept
    `SEM_ASSERT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready |=> !s_ready, "request accepted back to back")

    // results only come from interior pixels
    `SEM_ASSERT(a_interior_center, aclk, aresetn, m_valid |-> (m_center_x != {X_W{1'b0}}) && (m_center_y != {Y_W{1'b0}}), "result on a border pixel")

    // reset empties the output register
    `SEM_ASSERT_ALWAYS(a_reset_clears, aclk, !aresetn |=> !m_valid, "result valid after reset")

endmodule

bind sobel_edge_magnitude_core sem_checker u_sem_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_valid          (s_valid),
    .s_ready          (s_ready),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_edge_magnitude (m_edge_magnitude),
    .m_center_x       (m_center_x),
    .m_center_y       (m_center_y),
    .m_last_of_frame  (m_last_of_frame)
);

`default_nettype wire

/* dv/sobel_edge_magnitude_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_core_tb
// streams grayscale frames into the core under bursty requests and random
// result back-pressure; a cycle-free model of the line stores and the 3x3
// window predicts every interior magnitude, which is checked in order
// ----------------------------------------------------------------------------

module sobel_edge_magnitude_core_tb;

    import sem_pkg::*;

    localparam int LINE_MAX     = MAX_WIDTH_DEF;
    localparam int ROWS_MAX     = MAX_HEIGHT_DEF;
    localparam int DRAIN_CYCLES = 20;     // well past the result latency
    localparam int STALL_LIMIT  = 2000;   // cycles with no request and no result
    localparam int RANDOM_ITEMS = 990;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             sof;
    } pixel_req_t;

    typedef struct packed {
        logic [MAG_W-1:0] magnitude;
        logic [X_W-1:0]   center_x;
        logic [Y_W-1:0]   center_y;
        logic             frame_last;
    } edge_result_t;

    // pixel content styles for generated frames
    typedef enum int {
        FILL_NOISE,
        FILL_FLAT,
        FILL_BINARY,
        FILL_RAMP
    } fill_t;

    logic                aclk;
    logic                aresetn          = 1'b0;
    logic                s_valid          = 1'b0;
    logic                s_ready;
    logic [PIX_W-1:0]    s_pixel          = '0;
    logic                s_start_of_frame = 1'b0;
    logic                m_valid;
    logic                m_ready          = 1'b0;
    logic [MAG_W-1:0]    m_edge_magnitude;
    logic [X_W-1:0]      m_center_x;
    logic [Y_W-1:0]      m_center_y;
    logic                m_last_of_frame;
    logic                psel             = 1'b0;
    logic                penable          = 1'b0;
    logic                pwrite           = 1'b0;
    logic [CFG_AW-1:0]   paddr            = '0;
    logic [CFG_DW-1:0]   pwdata           = '0;
    logic [CFG_DW-1:0]   prdata;
    logic                pready;

    sobel_edge_magnitude_core dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_pixel          (s_pixel),
        .s_start_of_frame (s_start_of_frame),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_edge_magnitude (m_edge_magnitude),
        .m_center_x       (m_center_x),
        .m_center_y       (m_center_y),
        .m_last_of_frame  (m_last_of_frame),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // pending pixel requests and the magnitudes they are expected to produce
    pixel_req_t   pixel_requests[$];
    edge_result_t expected_edges[$];
    int           error_count = 0;

    // ------------------------------------------------------------------
    // predictor state: register copies, line stores, window, position
    // ------------------------------------------------------------------
    logic [X_W-1:0]   width_reg  = WIDTH_RST;
    logic [Y_W-1:0]   height_reg = HEIGHT_RST;
    logic [PIX_W-1:0] upper_line [LINE_MAX];
    logic [PIX_W-1:0] middle_line [LINE_MAX];
    // 0..2: column two back (top, mid, bottom); 3..5: previous column
    logic [PIX_W-1:0] window_px [6];
    int               col_pos;
    int               row_pos;

    // registers out of range saturate to the supported frame size
    function automatic int clamp_dim(input int raw, input int hi);
        if (raw < 3) return 3;
        if (raw > hi) return hi;
        return raw;
    endfunction

    // truncated square root, one result bit per trial from the top down
    function automatic logic [MAG_W-1:0] root_floor(input int unsigned v);
        logic [MAG_W-1:0] r;
        int unsigned      trial;
        r = '0;
        for (int b = MAG_W - 1; b >= 0; b--) begin
            trial = r | (1 << b);
            if (trial * trial <= v) r = trial[MAG_W-1:0];
        end
        return r;
    endfunction

    // advance the window by one accepted pixel; queue a magnitude when the
    // pixel completes an interior neighborhood
    function automatic void sobel_predict(input pixel_req_t req);
        int           w, h, col, row, p, t, m;
        int           lt, lm, lb, ct, cb, gx, gy;
        int unsigned  sq;
        edge_result_t r;
        w = clamp_dim(width_reg, LINE_MAX);
        h = clamp_dim(height_reg, ROWS_MAX);
        p = req.pixel;
        if (req.sof) begin
            col_pos = 0;
            row_pos = 0;
        end
        // a width shrunk mid-line pushes the position onto the next row
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
        end
        if (row_pos >= h) row_pos = 0;
        col = col_pos;
        row = row_pos;
        t = upper_line[col];
        m = middle_line[col];

        if (col >= 2 && row >= 2) begin
            lt = window_px[0];
            lm = window_px[1];
            lb = window_px[2];
            ct = window_px[3];
            cb = window_px[5];
            gx = (t - lt) + 2 * (m - lm) + (p - lb);
            gy = (lb + 2 * cb + p) - (lt + 2 * ct + t);
            sq = gx * gx + gy * gy;
            r.magnitude  = (sq >= SAT_LIMIT) ? MAG_SAT : root_floor(sq);
            r.center_x   = X_W'(col - 1);
            r.center_y   = Y_W'(row - 1);
            r.frame_last = (col == w - 1) && (row == h - 1);
            expected_edges.push_back(r);
        end

        window_px[0] = window_px[3];
        window_px[1] = window_px[4];
        window_px[2] = window_px[5];
        window_px[3] = PIX_W'(t);
        window_px[4] = PIX_W'(m);
        window_px[5] = req.pixel;
        upper_line[col]  = PIX_W'(m);
        middle_line[col] = req.pixel;

        col_pos = col + 1;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos = row + 1;
            if (row_pos >= h) row_pos = 0;
        end
    endfunction

    // ------------------------------------------------------------------
    // request driver: bursts of random length, random gaps in between
    // ------------------------------------------------------------------
    int         burst_left = 0;
    int         gap_left   = 0;
    pixel_req_t taken_req;
    pixel_req_t next_req;

    function automatic int pick_gap();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 4) return 0;
        if (sel < 9) return $urandom_range(1, 6);
        return $urandom_range(10, 25);
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            // accepted request goes straight into the predictor
            if (s_valid && s_ready) begin
                taken_req.pixel = s_pixel;
                taken_req.sof   = s_start_of_frame;
                sobel_predict(taken_req);
            end
            // the request slot is free for the next cycle
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (pixel_requests.size() != 0) begin
                    next_req = pixel_requests.pop_front();
                    s_valid          <= 1'b1;
                    s_pixel          <= next_req.pixel;
                    s_start_of_frame <= next_req.sof;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 31);
                        gap_left   = pick_gap();
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // result back-pressure: ready runs alternating with stall runs
    // ------------------------------------------------------------------
    int ready_run = 0;
    int stall_run = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            ready_run = 0;
            stall_run = 0;
        end else if (ready_run > 0) begin
            m_ready <= 1'b1;
            ready_run--;
        end else if (stall_run > 0) begin
            m_ready <= 1'b0;
            stall_run--;
        end else begin
            m_ready <= 1'b1;
            ready_run = $urandom_range(1, 40);
            stall_run = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
        end
    end

    // ------------------------------------------------------------------
    // result monitor: in-order compare against the oldest expectation
    // ------------------------------------------------------------------
    edge_result_t got_edge;
    edge_result_t want_edge;

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            got_edge = {m_edge_magnitude, m_center_x, m_center_y, m_last_of_frame};
            if (expected_edges.size() == 0) begin
                $display("%0t: unexpected result: mag %0d x %0d y %0d last %0b", $time,
                         got_edge.magnitude, got_edge.center_x, got_edge.center_y,
                         got_edge.frame_last);
                error_count++;
            end else begin
                want_edge = expected_edges.pop_front();
                if (got_edge !== want_edge) begin
                    $display("%0t: result mismatch: expected mag %0d x %0d y %0d last %0b",
                             $time, want_edge.magnitude, want_edge.center_x,
                             want_edge.center_y, want_edge.frame_last);
                    $display("%0t:                    actual mag %0d x %0d y %0d last %0b",
                             $time, got_edge.magnitude, got_edge.center_x,
                             got_edge.center_y, got_edge.frame_last);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog: too long with neither a request nor a result accepted
    // ------------------------------------------------------------------
    int idle_cycles = 0;

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic void push_pixel(input logic [PIX_W-1:0] pix, input logic sof);
        pixel_req_t req;
        req.pixel = pix;
        req.sof   = sof;
        pixel_requests.push_back(req);
    endfunction

    // queue count pixels of a frame w wide; stray restarts only when allowed
    function automatic void push_frame(input int w, input int count, input logic sof_first,
                                       input logic stray_sof, input fill_t fill);
        int               base, v;
        logic [PIX_W-1:0] pix;
        logic             sof;
        base = $urandom_range(0, 255);
        for (int i = 0; i < count; i++) begin
            case (fill)
                FILL_NOISE:  pix = PIX_W'($urandom_range(0, 255));
                FILL_FLAT:   pix = PIX_W'(base);
                FILL_BINARY: pix = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                default: begin
                    // gentle horizontal ramp keeps magnitudes below saturation while row-aligned
                    v = base / 2 + (i % w) * 2 + $urandom_range(0, 3);
                    pix = (v > 255) ? 8'hFF : PIX_W'(v);
                end
            endcase
            if (i == 0) sof = sof_first;
            else sof = stray_sof && ($urandom_range(0, 299) == 0);
            push_pixel(pix, sof);
        end
    endfunction

    function automatic int unsigned pick_width();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0) return $urandom_range(0, 2);
        if (sel == 1) return $urandom_range(13, 40);
        return $urandom_range(3, 12);
    endfunction

    function automatic int unsigned pick_height();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0) return $urandom_range(0, 2);
        if (sel == 1) return $urandom_range(9, 20);
        return $urandom_range(3, 8);
    endfunction

    // register write: setup then access cycle; upper data bits are junk
    task automatic write_reg(input logic sel, input int unsigned raw);
        logic [CFG_DW-1:0] word;
        word = $urandom;
        if (sel == REG_WIDTH) word[X_W-1:0] = raw[X_W-1:0];
        else word[Y_W-1:0] = raw[Y_W-1:0];
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_AW'({sel, 2'b00});
        pwdata  <= word;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (sel == REG_WIDTH) width_reg = word[X_W-1:0];
        else height_reg = word[Y_W-1:0];
    endtask

    // hold off until every request is taken and every result is back,
    // then let border pixels still in flight finish
    task automatic wait_drained();
        while (pixel_requests.size() != 0 || s_valid || expected_edges.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        int   w_eff, h_eff, frames, len, random_items;
        logic next_sof;

        for (int i = 0; i < LINE_MAX; i++) begin
            upper_line[i]  = '0;
            middle_line[i] = '0;
        end
        for (int i = 0; i < 6; i++) window_px[i] = '0;
        col_pos = 0;
        row_pos = 0;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // smallest frame: width and height below range clamp to 3x3
        write_reg(REG_WIDTH, 0);
        write_reg(REG_HEIGHT, 2);
        // dark left column, bright right column: saturated magnitude
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                push_pixel((c == 2) ? 8'hFF : (r == 1 && c == 1) ? 8'h80 : 8'h00,
                           r == 0 && c == 0);
        // overrun with no start marker: wraps to a new frame on its own
        for (int i = 0; i < 9; i++) push_pixel((i == 8) ? 8'd10 : 8'd0, 1'b0);
        // flat white frame: zero gradient
        for (int i = 0; i < 9; i++) push_pixel(8'hFF, i == 0);
        wait_drained();

        // width shrunk mid-frame: the next column lies past the new edge
        write_reg(REG_WIDTH, 8);
        write_reg(REG_HEIGHT, 6);
        push_frame(8, 20, 1'b1, 1'b0, FILL_NOISE);
        wait_drained();
        write_reg(REG_WIDTH, 3);
        push_frame(3, 12, 1'b0, 1'b0, FILL_NOISE);
        wait_drained();

        // random phases of mostly whole frames, some cut short or overrun
        random_items = 0;
        while (random_items < RANDOM_ITEMS) begin
            if ($urandom_range(0, 3) != 0) write_reg(REG_WIDTH, pick_width());
            write_reg(REG_HEIGHT, pick_height());
            w_eff    = clamp_dim(width_reg, LINE_MAX);
            h_eff    = clamp_dim(height_reg, ROWS_MAX);
            frames   = $urandom_range(1, 3);
            next_sof = 1'b1;
            for (int f = 0; f < frames && random_items < RANDOM_ITEMS; f++) begin
                len = ($urandom_range(0, 4) != 0) ? w_eff * h_eff
                                                  : $urandom_range(1, w_eff * h_eff);
                // keep the whole run close to its item budget
                if (len > RANDOM_ITEMS - random_items) len = RANDOM_ITEMS - random_items;
                push_frame(w_eff, len, next_sof, 1'b1, fill_t'($urandom_range(0, 3)));
                random_items += len;
                next_sof = ($urandom_range(0, 3) != 0);
            end
            wait_drained();
        end

        if (error_count == 0 && expected_edges.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
